// ===== hdl/page_framebuffer_line_draw_defines.svh =====
// Assertion macros shared by the framebuffer line-draw RTL.
`ifndef PAGE_FRAMEBUFFER_LINE_DRAW_DEFINES_SVH
`define PAGE_FRAMEBUFFER_LINE_DRAW_DEFINES_SVH

// Same-cycle implication, checked on aclk, off while aresetn is low.
`define PFLD_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("pfld assertion failed");

// Next-cycle implication, checked on aclk, off while aresetn is low.
`define PFLD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("pfld assertion failed");

`endif

// ===== hdl/pfld_pkg.sv =====
// Shared types and constants for the page framebuffer line drawer.
package pfld_pkg;

    localparam int SCREEN_WIDTH  = 128;
    localparam int SCREEN_HEIGHT = 64;
    localparam int STORE_DEPTH   = 1024;
    localparam int ADDR_W        = 10;
    localparam int BYTE_W        = 8;
    localparam int COORD_W       = 10;
    localparam int DELTA_W       = COORD_W + 1;
    localparam int LEN_W         = COORD_W;
    localparam int FRAC_W        = 8;
    localparam int POS_W         = 12;
    localparam int ACC_W         = POS_W + FRAC_W;
    localparam int PIX_ADDR_W    = 14;
    localparam int DIVIDEND_W    = LEN_W + FRAC_W;
    localparam int QUO_W         = FRAC_W + 1;
    localparam int DIV_CNT_W     = 5;
    localparam int TDATA_W       = 64;
    localparam int TUSER_W       = 2;
    localparam logic [FRAC_W-1:0] ACC_HALF = 8'h80;

    typedef enum logic [1:0] {
        OP_DRAW = 2'd0,
        OP_READ = 2'd1,
        OP_FILL = 2'd2,
        OP_NONE = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        COLOR_CLEAR  = 2'd0,
        COLOR_SET    = 2'd1,
        COLOR_TOGGLE = 2'd2,
        COLOR_KEEP   = 2'd3
    } color_t;

    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] mask;
        color_t            color;
    } pix_req_t;

    typedef struct packed {
        logic              fill_start;
        logic [BYTE_W-1:0] fill_value;
        logic [ADDR_W-1:0] rd_addr;
    } store_ctl_t;

    typedef struct packed {
        logic              busy;
        logic [BYTE_W-1:0] rd_data;
    } store_stat_t;

endpackage

// ===== hdl/page_framebuffer_line_draw.sv =====
// Top level of the page-layout framebuffer with fixed-point DDA line drawing.
// The 128x64 monochrome framebuffer lives in one 1024-byte RAM (registered
// read), each byte holding 8 vertically stacked pixels at address
// x + (y / 8) * 128. After reset the block clears the whole RAM and holds
// s_axis_tready low meanwhile. Every item yields exactly one result byte on
// the m_axis side. A draw runs the serial slope divider, then walks the longer
// axis length plus one pixels through the RAM read-modify-write pipeline, which
// takes one pixel per cycle with forwarding, then waits for it to drain; a read
// registers one RAM byte; a fill sweeps the RAM writing one byte a cycle; an
// unused opcode goes straight to the result register.
// One item is worked on at a time; the result register lets the next item in
// while the previous result still waits for m_axis_tready.
module page_framebuffer_line_draw (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // x_start[9:0], y_start[19:10], x_end[29:20], y_end[39:30],
    // pixel_color[41:40], byte_address[51:42], fill_value[59:52], zero pad
    input  logic [pfld_pkg::TDATA_W-1:0]   s_axis_tdata,
    // opcode[1:0]
    input  logic [pfld_pkg::TUSER_W-1:0]   s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // read_data[7:0]
    output logic [pfld_pkg::BYTE_W-1:0]    m_axis_tdata
);
    import pfld_pkg::*;

    `include "page_framebuffer_line_draw_defines.svh"

    typedef enum logic [7:0] {
        ST_CLEAR = 8'b0000_0001,
        ST_IDLE  = 8'b0000_0010,
        ST_DIV   = 8'b0000_0100,
        ST_WALK  = 8'b0000_1000,
        ST_DRAIN = 8'b0001_0000,
        ST_READ  = 8'b0010_0000,
        ST_FILL  = 8'b0100_0000,
        ST_DONE  = 8'b1000_0000
    } state_t;

    // unpack the input item
    op_t                      in_op;
    logic signed [COORD_W-1:0] in_x0, in_y0, in_x1, in_y1;
    color_t                   in_color;
    logic [ADDR_W-1:0]        in_addr;
    logic [BYTE_W-1:0]        in_fill;

    assign in_op    = op_t'(s_axis_tuser);
    assign in_x0    = s_axis_tdata[9:0];
    assign in_y0    = s_axis_tdata[19:10];
    assign in_x1    = s_axis_tdata[29:20];
    assign in_y1    = s_axis_tdata[39:30];
    assign in_color = color_t'(s_axis_tdata[41:40]);
    assign in_addr  = s_axis_tdata[51:42];
    assign in_fill  = s_axis_tdata[59:52];

    state_t state_reg, state_next;
    logic   in_accept;

    // line setup from the raw endpoints
    logic signed [DELTA_W-1:0] dx, dy;
    logic [LEN_W-1:0]          adx, ady, along, ashort;
    logic                      ymajor, dshort_neg;

    assign dx     = DELTA_W'(in_x1) - DELTA_W'(in_x0);
    assign dy     = DELTA_W'(in_y1) - DELTA_W'(in_y0);
    assign adx    = dx[DELTA_W-1] ? LEN_W'(-dx) : LEN_W'(dx);
    assign ady    = dy[DELTA_W-1] ? LEN_W'(-dy) : LEN_W'(dy);
    assign ymajor = ady > adx;    // equal lengths walk along x
    assign along  = ymajor ? ady : adx;
    assign ashort = ymajor ? adx : ady;
    assign dshort_neg = ymajor ? dx[DELTA_W-1] : dy[DELTA_W-1];

    // walker registers
    logic                      ymajor_reg, ymajor_next;
    logic                      dir_neg_reg, dir_neg_next;
    logic                      sneg_reg, sneg_next;
    logic [LEN_W-1:0]          cnt_reg, cnt_next;
    logic signed [POS_W-1:0]   major_reg, major_next;
    logic signed [COORD_W-1:0] minor0_reg, minor0_next;
    logic signed [ACC_W-1:0]   acc_reg, acc_next;
    logic signed [ACC_W-1:0]   step_reg, step_next;
    color_t                    color_reg, color_next;

    logic                      m_valid_reg, m_valid_next;
    logic [BYTE_W-1:0]         m_data_reg, m_data_next;
    logic [BYTE_W-1:0]         res_reg, res_next;

    // divider
    logic                      div_start, div_busy;
    logic [QUO_W-1:0]          div_quo;
    logic [ACC_W-1:0]          quo_ext;

    assign div_start = in_accept && (in_op == OP_DRAW);
    assign quo_ext   = ACC_W'(div_quo);

    pfld_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend ({ashort, {FRAC_W{1'b0}}}),
        .divisor  (along),
        .busy     (div_busy),
        .quotient (div_quo)
    );

    // current pixel: floor of the accumulator on the minor axis
    logic signed [POS_W-1:0]   minor_pos, px, py;
    logic                      on_screen, addr_ok;
    logic [PIX_ADDR_W-1:0]     pix_addr_wide;

    assign minor_pos = acc_reg[ACC_W-1:FRAC_W];
    assign px = ymajor_reg ? minor_pos : major_reg;
    assign py = ymajor_reg ? major_reg : minor_pos;

    assign on_screen = !px[POS_W-1] && (px < POS_W'(SCREEN_WIDTH)) &&
                       !py[POS_W-1] && (py < POS_W'(SCREEN_HEIGHT));
    assign pix_addr_wide = PIX_ADDR_W'(px[7:0]) +
                           PIX_ADDR_W'(py[7:3]) * PIX_ADDR_W'(SCREEN_WIDTH);
    assign addr_ok = pix_addr_wide < PIX_ADDR_W'(STORE_DEPTH);

    pix_req_t    pix;
    store_ctl_t  ctl;
    store_stat_t stat;

    assign pix.valid = (state_reg == ST_WALK) && on_screen && addr_ok;
    assign pix.addr  = pix_addr_wide[ADDR_W-1:0];
    assign pix.mask  = BYTE_W'(1) << py[2:0];
    assign pix.color = color_reg;

    assign ctl.fill_start = in_accept && (in_op == OP_FILL);
    assign ctl.fill_value = in_fill;
    assign ctl.rd_addr    = in_addr;

    pfld_store u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .pix     (pix),
        .ctl     (ctl),
        .stat    (stat)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    always_comb begin
        state_next   = state_reg;
        ymajor_next  = ymajor_reg;
        dir_neg_next = dir_neg_reg;
        sneg_next    = sneg_reg;
        cnt_next     = cnt_reg;
        major_next   = major_reg;
        minor0_next  = minor0_reg;
        acc_next     = acc_reg;
        step_next    = step_reg;
        color_next   = color_reg;
        res_next     = res_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;

        // drop the result once taken
        if (m_valid_reg && m_axis_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR: begin
                if (!stat.busy) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_accept) begin
                    res_next = '0;
                    unique case (in_op)
                        OP_DRAW: begin
                            ymajor_next  = ymajor;
                            dir_neg_next = ymajor ? dy[DELTA_W-1] : dx[DELTA_W-1];
                            sneg_next    = dshort_neg;
                            cnt_next     = along;
                            major_next   = POS_W'(ymajor ? in_y0 : in_x0);
                            minor0_next  = ymajor ? in_x0 : in_y0;
                            color_next   = in_color;
                            state_next   = ST_DIV;
                        end
                        OP_READ: state_next = ST_READ;
                        OP_FILL: state_next = ST_FILL;
                        OP_NONE: state_next = ST_DONE;
                        default: state_next = ST_DONE;
                    endcase
                end
            end
            ST_DIV: begin
                // start at the pixel center, advance by the signed slope
                if (!div_busy) begin
                    acc_next   = {POS_W'(minor0_reg), ACC_HALF};
                    step_next  = sneg_reg ? -quo_ext : quo_ext;
                    state_next = ST_WALK;
                end
            end
            ST_WALK: begin
                major_next = dir_neg_reg ? major_reg - 1'b1 : major_reg + 1'b1;
                acc_next   = acc_reg + step_reg;
                cnt_next   = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!stat.busy) begin
                    state_next = ST_DONE;
                end
            end
            ST_READ: begin
                res_next   = stat.rd_data;
                state_next = ST_DONE;
            end
            ST_FILL: begin
                if (!stat.busy) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                // hold until the result register is free
                if (!m_valid_reg || m_axis_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            m_valid_reg <= 1'b0;
            cnt_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            cnt_reg     <= cnt_next;
        end
        ymajor_reg  <= ymajor_next;
        dir_neg_reg <= dir_neg_next;
        sneg_reg    <= sneg_next;
        major_reg   <= major_next;
        minor0_reg  <= minor0_next;
        acc_reg     <= acc_next;
        step_reg    <= step_next;
        color_reg   <= color_next;
        res_reg     <= res_next;
        m_data_reg  <= m_data_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    `PFLD_ASSERT_NEXT(a_accept_closes_input, in_accept, !s_axis_tready)
    `PFLD_ASSERT_NEXT(a_walk_ends_in_drain, (state_reg == ST_WALK) && (cnt_reg == '0), state_reg == ST_DRAIN)
    `PFLD_ASSERT_IMPL(a_pixels_only_in_walk, pix.valid, state_reg == ST_WALK)

endmodule

// ===== hdl/pfld_div.sv =====
// Bit-serial restoring divider for the line slope magnitude.
module pfld_div (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  logic [pfld_pkg::DIVIDEND_W-1:0]   dividend,
    input  logic [pfld_pkg::LEN_W-1:0]        divisor,
    output logic                              busy,
    output logic [pfld_pkg::QUO_W-1:0]        quotient
);
    import pfld_pkg::*;

    logic                  busy_reg, busy_next;
    logic [DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [LEN_W-1:0]      rem_reg, rem_next;
    logic [DIVIDEND_W-1:0] dvd_reg, dvd_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [LEN_W-1:0]      div_reg, div_next;
    logic                  zero_reg, zero_next;
    logic [LEN_W:0]        trial;
    logic                  fits;

    assign trial = {rem_reg, dvd_reg[DIVIDEND_W-1]};
    assign fits  = trial >= {1'b0, div_reg};

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        quo_next  = quo_reg;
        div_next  = div_reg;
        zero_next = zero_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(DIVIDEND_W - 1);
            rem_next  = '0;
            dvd_next  = dividend;
            quo_next  = '0;
            div_next  = divisor;
            zero_next = (divisor == '0);
        end else if (busy_reg) begin
            // one quotient bit per cycle
            rem_next = fits ? LEN_W'(trial - {1'b0, div_reg}) : trial[LEN_W-1:0];
            dvd_next = {dvd_reg[DIVIDEND_W-2:0], 1'b0};
            quo_next = {quo_reg[DIVIDEND_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg  <= rem_next;
        dvd_reg  <= dvd_next;
        quo_reg  <= quo_next;
        div_reg  <= div_next;
        zero_reg <= zero_next;
    end

    assign busy     = busy_reg;
    assign quotient = zero_reg ? '0 : quo_reg[QUO_W-1:0];

endmodule

// ===== hdl/pfld_store.sv =====
// Framebuffer memory with pixel read-modify-write, byte read and fill sweep.
module pfld_store (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  pfld_pkg::pix_req_t      pix,
    input  pfld_pkg::store_ctl_t    ctl,
    output pfld_pkg::store_stat_t   stat
);
    import pfld_pkg::*;

    `include "page_framebuffer_line_draw_defines.svh"

    logic [BYTE_W-1:0] mem [STORE_DEPTH];
    logic [BYTE_W-1:0] q_reg;

    logic              sweep_active_reg, sweep_active_next;
    logic [ADDR_W-1:0] sweep_addr_reg, sweep_addr_next;
    logic [BYTE_W-1:0] sweep_value_reg, sweep_value_next;

    logic              s2_valid_reg;
    logic [ADDR_W-1:0] s2_addr_reg;
    logic [BYTE_W-1:0] s2_mask_reg;
    color_t            s2_color_reg;

    logic              fwd_valid_reg;
    logic [ADDR_W-1:0] fwd_addr_reg;
    logic [BYTE_W-1:0] fwd_data_reg;

    logic [BYTE_W-1:0] old_byte, new_byte;
    logic              we;
    logic [ADDR_W-1:0] wa, ra;
    logic [BYTE_W-1:0] wd;

    // take the byte written last cycle: the RAM read of that cycle saw the old one
    assign old_byte = (fwd_valid_reg && fwd_addr_reg == s2_addr_reg) ? fwd_data_reg : q_reg;

    always_comb begin
        unique case (s2_color_reg)
            COLOR_CLEAR:  new_byte = old_byte & ~s2_mask_reg;
            COLOR_SET:    new_byte = old_byte | s2_mask_reg;
            COLOR_TOGGLE: new_byte = old_byte ^ s2_mask_reg;
            COLOR_KEEP:   new_byte = old_byte;
            default:      new_byte = old_byte;
        endcase
    end

    assign we = sweep_active_reg || s2_valid_reg;
    assign wa = sweep_active_reg ? sweep_addr_reg : s2_addr_reg;
    assign wd = sweep_active_reg ? sweep_value_reg : new_byte;
    assign ra = pix.valid ? pix.addr : ctl.rd_addr;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        q_reg <= mem[ra];
    end

    always_comb begin
        sweep_active_next = sweep_active_reg;
        sweep_addr_next   = sweep_addr_reg;
        sweep_value_next  = sweep_value_reg;
        if (ctl.fill_start) begin
            sweep_active_next = 1'b1;
            sweep_addr_next   = '0;
            sweep_value_next  = ctl.fill_value;
        end else if (sweep_active_reg) begin
            sweep_addr_next = sweep_addr_reg + 1'b1;
            if (sweep_addr_reg == ADDR_W'(STORE_DEPTH - 1)) begin
                sweep_active_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            // clear the whole store after reset
            sweep_active_reg <= 1'b1;
            sweep_addr_reg   <= '0;
            sweep_value_reg  <= '0;
            s2_valid_reg     <= 1'b0;
            fwd_valid_reg    <= 1'b0;
        end else begin
            sweep_active_reg <= sweep_active_next;
            sweep_addr_reg   <= sweep_addr_next;
            sweep_value_reg  <= sweep_value_next;
            s2_valid_reg     <= pix.valid;
            fwd_valid_reg    <= s2_valid_reg;
        end
        s2_addr_reg  <= pix.addr;
        s2_mask_reg  <= pix.mask;
        s2_color_reg <= pix.color;
        fwd_addr_reg <= s2_addr_reg;
        fwd_data_reg <= new_byte;
    end

    assign stat.busy    = sweep_active_reg || s2_valid_reg;
    assign stat.rd_data = q_reg;

    `PFLD_ASSERT_IMPL(a_no_pixel_during_sweep, sweep_active_reg, !s2_valid_reg)
    `PFLD_ASSERT_NEXT(a_pixel_reaches_write, pix.valid, s2_valid_reg)
    `PFLD_ASSERT_NEXT(a_fill_starts_sweep, ctl.fill_start, sweep_active_reg && stat.busy)

endmodule
